// File: src/hjd_pkg.sv
// Shared types and constants of the headset jack and hook detector.
// Holds the configuration, item structs and the action, event and register codes.
// No dependencies.
package hjd_pkg;

  localparam int ADC_BITS    = 12;
  localparam int ADC_FIELD_W = 12;
  localparam int ADC_USE_W   = (ADC_BITS < ADC_FIELD_W) ? ADC_BITS : ADC_FIELD_W;
  localparam int CEIL_W      = ADC_FIELD_W + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = CEIL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INSERT_LEVEL_HIGH  = 3'd0,
    CFG_MIC_DETECT_ENABLED = 3'd1,
    CFG_HOOK_LOW_LEVEL     = 3'd2,
    CFG_HOOK_HIGH_LEVEL    = 3'd3,
    CFG_ADC_CEILING        = 3'd4
  } cfg_idx_e;

  typedef logic [1:0] action_t;
  localparam action_t ACT_JACK = 2'd0;
  localparam action_t ACT_MIC  = 2'd1;
  localparam action_t ACT_HOOK = 2'd2;

  typedef logic [1:0] jack_evt_t;
  localparam jack_evt_t JEV_NONE      = 2'd0;
  localparam jack_evt_t JEV_HEADSET   = 2'd1;
  localparam jack_evt_t JEV_HEADPHONE = 2'd2;
  localparam jack_evt_t JEV_REMOVED   = 2'd3;

  localparam logic [ADC_FIELD_W-1:0] HOOK_LOW_RST  = ADC_FIELD_W'(204);
  localparam logic [ADC_FIELD_W-1:0] HOOK_HIGH_RST = ADC_FIELD_W'(410);
  localparam logic [CEIL_W-1:0]      CEILING_RST   = CEIL_W'(1024);

  typedef struct packed {
    logic                   insert_level_high;
    logic                   mic_detect_enabled;
    logic [ADC_FIELD_W-1:0] hook_low_level;
    logic [ADC_FIELD_W-1:0] hook_high_level;
    logic [CEIL_W-1:0]      adc_ceiling;
  } hjd_cfg_t;

  typedef struct packed {
    action_t                action;
    logic                   jack_level;
    logic [ADC_FIELD_W-1:0] adc_value;
    logic                   adc_valid;
  } hjd_in_t;

  typedef struct packed {
    logic      now_inserted;
    logic      now_mic;
    logic      now_hook_down;
    jack_evt_t jack_event;
    logic      hook_event;
    logic      want_mic_check;
    logic      want_hook_poll;
    logic      stop_hook_poll;
  } hjd_out_t;

endpackage

// File: src/hjd_if.sv
// Valid/ready channel interfaces for detector input samples and results.
// Depends on hjd_pkg for the payload structs.
interface hjd_in_if;
  import hjd_pkg::*;
  logic    valid;
  logic    ready;
  hjd_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface hjd_out_if;
  import hjd_pkg::*;
  logic     valid;
  logic     ready;
  hjd_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: src/hjd_cfg.sv
// Configuration register file of the detector.
// Depends on hjd_pkg for the register codes and hjd_cfg_t.
module hjd_cfg
  import hjd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output hjd_cfg_t              cfg_o
);

  hjd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INSERT_LEVEL_HIGH:  cfg_d.insert_level_high  = cfg_wdata_i[0];
        CFG_MIC_DETECT_ENABLED: cfg_d.mic_detect_enabled = cfg_wdata_i[0];
        CFG_HOOK_LOW_LEVEL:     cfg_d.hook_low_level  = cfg_wdata_i[ADC_FIELD_W-1:0];
        CFG_HOOK_HIGH_LEVEL:    cfg_d.hook_high_level = cfg_wdata_i[ADC_FIELD_W-1:0];
        CFG_ADC_CEILING:        cfg_d.adc_ceiling     = cfg_wdata_i[CEIL_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.insert_level_high  <= 1'b1;
      cfg_q.mic_detect_enabled <= 1'b1;
      cfg_q.hook_low_level     <= HOOK_LOW_RST;
      cfg_q.hook_high_level    <= HOOK_HIGH_RST;
      cfg_q.adc_ceiling        <= CEILING_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/hjd_core.sv
// Input register, plug/mic/hook state and result register of the detector.
// Depends on hjd_pkg and the channel interfaces in hjd_if.sv.
module hjd_core
  import hjd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  hjd_cfg_t  cfg_i,
  hjd_in_if.sink    in_ch,
  hjd_out_if.source out_ch
);

  logic     in_vld_q;
  hjd_in_t  in_q;
  logic     out_vld_q;
  hjd_out_t out_q;
  hjd_out_t res_d;
  logic     plug_q, mic_q, hook_q;
  logic     plug_d, mic_d, hook_d;
  logic     adv_out;
  logic     pin_in;
  logic [ADC_FIELD_W-1:0] adc;
  logic     below_low, at_high, above_high, below_ceil;

  assign adv_out     = !out_vld_q || out_ch.ready;
  assign in_ch.ready = !in_vld_q || adv_out;

  assign adc        = ADC_FIELD_W'(in_q.adc_value[ADC_USE_W-1:0]);
  assign pin_in     = cfg_i.insert_level_high ? in_q.jack_level : !in_q.jack_level;
  assign below_low  = adc < cfg_i.hook_low_level;
  assign at_high    = adc >= cfg_i.hook_high_level;
  assign above_high = adc > cfg_i.hook_high_level;
  assign below_ceil = {1'b0, adc} < cfg_i.adc_ceiling;

  always_comb begin
    plug_d = plug_q;
    mic_d  = mic_q;
    hook_d = hook_q;
    res_d  = '0;
    case (in_q.action)
      ACT_JACK: begin
        if (pin_in != plug_q) begin
          plug_d = pin_in;
          if (pin_in) begin
            if (cfg_i.mic_detect_enabled) begin
              res_d.want_mic_check = 1'b1;
            end else begin
              mic_d = 1'b0;
              res_d.jack_event = JEV_HEADPHONE;
            end
          end else begin
            res_d.stop_hook_poll = 1'b1;
            if (mic_q) begin
              if (hook_q) begin
                hook_d = 1'b0;
                res_d.hook_event = 1'b1;
              end
              mic_d = 1'b0;
            end
            res_d.jack_event = JEV_REMOVED;
          end
        end
      end
      ACT_MIC: begin
        if (plug_q && cfg_i.mic_detect_enabled) begin
          if (in_q.adc_valid) begin
            if (below_low) begin
              mic_d = 1'b0;
            end else if (at_high) begin
              mic_d = 1'b1;
              res_d.want_hook_poll = 1'b1;
            end
          end
          res_d.jack_event = mic_d ? JEV_HEADSET : JEV_HEADPHONE;
        end
      end
      ACT_HOOK: begin
        if (in_q.adc_valid && plug_q && cfg_i.mic_detect_enabled && pin_in) begin
          if (below_low) begin
            hook_d = 1'b1;
          end else if (above_high && below_ceil) begin
            hook_d = 1'b0;
          end
          res_d.hook_event     = hook_d != hook_q;
          res_d.want_hook_poll = 1'b1;
        end
      end
      default: begin
        res_d = '0;
      end
    endcase
    res_d.now_inserted  = plug_d;
    res_d.now_mic       = mic_d;
    res_d.now_hook_down = hook_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      plug_q    <= 1'b0;
      mic_q     <= 1'b0;
      hook_q    <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_q <= in_ch.valid;
      end
      if (adv_out) begin
        out_vld_q <= in_vld_q;
      end
      if (adv_out && in_vld_q) begin
        plug_q <= plug_d;
        mic_q  <= mic_d;
        hook_q <= hook_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      in_q <= in_ch.payload;
    end
    if (adv_out && in_vld_q) begin
      out_q <= res_d;
    end
  end

  assign out_ch.valid   = out_vld_q;
  assign out_ch.payload = out_q;

  a_mic_needs_plug: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !plug_q |-> !mic_q)
    else $error("mic state set while headset out");

  a_mic_check_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.want_mic_check |-> out_q.now_inserted && !out_q.now_mic)
    else $error("mic check requested without a fresh insertion");

  a_stop_on_removal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.stop_hook_poll |->
      out_q.jack_event == JEV_REMOVED && !out_q.now_inserted && !out_q.now_mic)
    else $error("poll stop without a clean removal");

  a_state_tracks_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_out && in_vld_q |=>
      out_q.now_inserted == plug_q && out_q.now_mic == mic_q && out_q.now_hook_down == hook_q)
    else $error("result state differs from held state");

endmodule

// File: src/headset_jack_and_hook_detector.sv
// Channel    | Dir | Payload                                  | Handshake
// in_ch      | in  | action, jack_level, adc_value, adc_valid | valid/ready
// out_ch     | out | state flags, jack/hook events, requests  | valid/ready
// cfg_*_i    | in  | register index and write data            | write enable
// One item per clock sustained while out_ch is ready; an accepted item is held in the input
// register, and its result is loaded into the result register when that register can advance.
// Reset clears plug, mic and hook state and loads the register defaults.
// A stalled result holds; the input register still takes an item while it is empty or moving.
module headset_jack_and_hook_detector
  import hjd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  hjd_in_if.sink                in_ch,
  hjd_out_if.source             out_ch
);

  hjd_cfg_t cfg;

  hjd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  hjd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// File: verif/headset_jack_and_hook_detector_tb.sv
// Testbench for headset_jack_and_hook_detector: directed and random jack, mic and hook items.
// A scoreboard class predicts every result; depends on hjd_pkg, hjd_if and the detector RTL.
module headset_jack_and_hook_detector_tb;
  import hjd_pkg::*;

  localparam action_t ACT_UNUSED  = 2'd3;
  localparam int      HOLD_CYCLES = 400;
  localparam int      IDLE_LIMIT  = 20000;
  localparam int      SEG_ITEMS   = 310;

  class jack_hook_scoreboard;
    hjd_cfg_t cfg;
    logic     plug_in;
    logic     mic_seen;
    logic     key_pressed;
    hjd_out_t expected_results[$];
    int       mismatches;
    int       checked;

    function new();
      cfg.insert_level_high  = 1'b1;
      cfg.mic_detect_enabled = 1'b1;
      cfg.hook_low_level     = HOOK_LOW_RST;
      cfg.hook_high_level    = HOOK_HIGH_RST;
      cfg.adc_ceiling        = CEILING_RST;
      plug_in     = 1'b0;
      mic_seen    = 1'b0;
      key_pressed = 1'b0;
      mismatches  = 0;
      checked     = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_INSERT_LEVEL_HIGH:  cfg.insert_level_high  = val[0];
        CFG_MIC_DETECT_ENABLED: cfg.mic_detect_enabled = val[0];
        CFG_HOOK_LOW_LEVEL:     cfg.hook_low_level     = val[ADC_FIELD_W-1:0];
        CFG_HOOK_HIGH_LEVEL:    cfg.hook_high_level    = val[ADC_FIELD_W-1:0];
        CFG_ADC_CEILING:        cfg.adc_ceiling        = val[CEIL_W-1:0];
        default: ;
      endcase
    endfunction

    function logic pin_in(logic lvl);
      return cfg.insert_level_high ? lvl : ~lvl;
    endfunction

    function void note_sample(hjd_in_t s);
      hjd_out_t               r;
      logic [ADC_FIELD_W-1:0] adc;
      logic                   was_pressed;
      r   = '0;
      adc = s.adc_value & ADC_FIELD_W'((1 << ADC_USE_W) - 1);
      case (s.action)
        ACT_JACK: begin
          if (pin_in(s.jack_level) != plug_in) begin
            plug_in = pin_in(s.jack_level);
            if (plug_in) begin
              if (cfg.mic_detect_enabled) begin
                r.want_mic_check = 1'b1;
              end else begin
                mic_seen     = 1'b0;
                r.jack_event = JEV_HEADPHONE;
              end
            end else begin
              r.stop_hook_poll = 1'b1;
              if (mic_seen) begin
                if (key_pressed) begin
                  key_pressed  = 1'b0;
                  r.hook_event = 1'b1;
                end
                mic_seen = 1'b0;
              end
              r.jack_event = JEV_REMOVED;
            end
          end
        end
        ACT_MIC: begin
          if (plug_in && cfg.mic_detect_enabled) begin
            if (s.adc_valid) begin
              if (adc < cfg.hook_low_level) begin
                mic_seen = 1'b0;
              end else if (adc >= cfg.hook_high_level) begin
                mic_seen         = 1'b1;
                r.want_hook_poll = 1'b1;
              end
            end
            r.jack_event = mic_seen ? JEV_HEADSET : JEV_HEADPHONE;
          end
        end
        ACT_HOOK: begin
          if (s.adc_valid && plug_in && cfg.mic_detect_enabled && pin_in(s.jack_level)) begin
            was_pressed = key_pressed;
            if (adc < cfg.hook_low_level) begin
              key_pressed = 1'b1;
            end else if (adc > cfg.hook_high_level && adc < cfg.adc_ceiling) begin
              key_pressed = 1'b0;
            end
            r.hook_event     = (was_pressed != key_pressed);
            r.want_hook_poll = 1'b1;
          end
        end
        default: ;
      endcase
      r.now_inserted  = plug_in;
      r.now_mic       = mic_seen;
      r.now_hook_down = key_pressed;
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 40) $display("mismatch at result %0d: %s", checked, msg);
      mismatches++;
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(hjd_out_t got);
      hjd_out_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = expected_results.pop_front();
        compare_field("now_inserted", got.now_inserted, want.now_inserted);
        compare_field("now_mic", got.now_mic, want.now_mic);
        compare_field("now_hook_down", got.now_hook_down, want.now_hook_down);
        compare_field("jack_event", got.jack_event, want.jack_event);
        compare_field("hook_event", got.hook_event, want.hook_event);
        compare_field("want_mic_check", got.want_mic_check, want.want_mic_check);
        compare_field("want_hook_poll", got.want_hook_poll, want.want_hook_poll);
        compare_field("stop_hook_poll", got.stop_hook_poll, want.stop_hook_poll);
      end
      checked++;
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  hjd_in_if  in_ch ();
  hjd_out_if out_ch ();

  headset_jack_and_hook_detector u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  jack_hook_scoreboard sb = new();

  int src_idle_pct;
  int sink_idle_pct;
  int sent_items;
  bit hold_req;
  int hold_left;
  int quiet_cycles;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic hjd_in_t make_sample(action_t a, logic lvl, logic [ADC_FIELD_W-1:0] adc,
                                          logic vld);
    hjd_in_t s;
    s.action     = a;
    s.jack_level = lvl;
    s.adc_value  = adc;
    s.adc_valid  = vld;
    return s;
  endfunction

  function automatic logic [ADC_FIELD_W-1:0] pick_adc();
    int v;
    case ($urandom_range(9))
      0: v = 0;
      1: v = (1 << ADC_FIELD_W) - 1;
      2: v = int'(sb.cfg.hook_low_level) + int'($urandom_range(2)) - 1;
      3: v = int'(sb.cfg.hook_high_level) + int'($urandom_range(2)) - 1;
      4: v = int'(sb.cfg.adc_ceiling) + int'($urandom_range(2)) - 1;
      default: v = $urandom_range((1 << ADC_FIELD_W) - 1);
    endcase
    if (v < 0) v = 0;
    if (v > (1 << ADC_FIELD_W) - 1) v = (1 << ADC_FIELD_W) - 1;
    return ADC_FIELD_W'(v);
  endfunction

  task automatic send_item(hjd_in_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= s;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_sample(s);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (sb.expected_results.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_config(hjd_cfg_t c);
    write_reg(CFG_INSERT_LEVEL_HIGH, CFG_DATA_W'(c.insert_level_high));
    write_reg(CFG_MIC_DETECT_ENABLED, CFG_DATA_W'(c.mic_detect_enabled));
    write_reg(CFG_HOOK_LOW_LEVEL, CFG_DATA_W'(c.hook_low_level));
    write_reg(CFG_HOOK_HIGH_LEVEL, CFG_DATA_W'(c.hook_high_level));
    write_reg(CFG_ADC_CEILING, CFG_DATA_W'(c.adc_ceiling));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic hjd_cfg_t make_cfg(logic ilh, logic mde, int lo, int hi, int ceil);
    hjd_cfg_t c;
    c.insert_level_high  = ilh;
    c.mic_detect_enabled = mde;
    c.hook_low_level     = ADC_FIELD_W'(lo);
    c.hook_high_level    = ADC_FIELD_W'(hi);
    c.adc_ceiling        = CEIL_W'(ceil);
    return c;
  endfunction

  task automatic run_directed();
    send_item(make_sample(ACT_UNUSED, 1'b1, 12'hfff, 1'b1));
    send_item(make_sample(ACT_JACK, 1'b0, 12'd0, 1'b0));
    send_item(make_sample(ACT_MIC, 1'b1, 12'd500, 1'b1));
    send_item(make_sample(ACT_HOOK, 1'b1, 12'd0, 1'b1));
    send_item(make_sample(ACT_JACK, 1'b1, 12'd0, 1'b0));
    send_item(make_sample(ACT_JACK, 1'b1, 12'hfff, 1'b1));
    send_item(make_sample(ACT_MIC, 1'b1, 12'd500, 1'b0));
    send_item(make_sample(ACT_MIC, 1'b1, 12'd300, 1'b1));
    send_item(make_sample(ACT_MIC, 1'b1, 12'd410, 1'b1));
    send_item(make_sample(ACT_HOOK, 1'b1, 12'd0, 1'b0));
    send_item(make_sample(ACT_HOOK, 1'b0, 12'd0, 1'b1));
    send_item(make_sample(ACT_HOOK, 1'b1, 12'd0, 1'b1));
    send_item(make_sample(ACT_HOOK, 1'b1, 12'd203, 1'b1));
    send_item(make_sample(ACT_HOOK, 1'b1, 12'd1024, 1'b1));
    send_item(make_sample(ACT_HOOK, 1'b1, 12'd411, 1'b1));
    send_item(make_sample(ACT_HOOK, 1'b1, 12'hfff, 1'b1));
    send_item(make_sample(ACT_HOOK, 1'b1, 12'd0, 1'b1));
    send_item(make_sample(ACT_JACK, 1'b0, 12'd0, 1'b1));
    send_item(make_sample(ACT_JACK, 1'b1, 12'd0, 1'b1));
    send_item(make_sample(ACT_MIC, 1'b1, 12'd203, 1'b1));
    send_item(make_sample(ACT_HOOK, 1'b1, 12'd0, 1'b1));
    send_item(make_sample(ACT_JACK, 1'b0, 12'd0, 1'b1));
    send_item(make_sample(ACT_UNUSED, 1'b0, 12'd0, 1'b0));
    wait_drained();
    apply_config(make_cfg(1'b0, 1'b0, 204, 410, 1024));
    send_item(make_sample(ACT_JACK, 1'b0, 12'd0, 1'b1));
    send_item(make_sample(ACT_MIC, 1'b0, 12'd500, 1'b1));
    send_item(make_sample(ACT_HOOK, 1'b0, 12'd0, 1'b1));
    send_item(make_sample(ACT_JACK, 1'b1, 12'd0, 1'b1));
  endtask

  task automatic play_session();
    logic in_lvl;
    logic lvl;
    int   polls;
    in_lvl = sb.cfg.insert_level_high;
    send_item(make_sample(ACT_JACK, in_lvl, pick_adc(), 1'($urandom_range(1))));
    if ($urandom_range(3) == 0)
      send_item(make_sample(ACT_JACK, in_lvl, pick_adc(), 1'($urandom_range(1))));
    send_item(make_sample(ACT_MIC, 1'($urandom_range(1)), pick_adc(), $urandom_range(9) != 0));
    polls = $urandom_range(1, 10);
    repeat (polls) begin
      lvl = ($urandom_range(9) == 0) ? ~in_lvl : in_lvl;
      if ($urandom_range(15) == 0) begin
        send_item(make_sample(ACT_MIC, lvl, pick_adc(), $urandom_range(9) != 0));
      end else begin
        send_item(make_sample(ACT_HOOK, lvl, pick_adc(), $urandom_range(9) != 0));
      end
    end
    send_item(make_sample(ACT_JACK, ~in_lvl, pick_adc(), 1'($urandom_range(1))));
  endtask

  task automatic run_random(int n, bit with_hold);
    int target;
    bit held;
    target = sent_items + n;
    held   = 1'b0;
    while (sent_items < target) begin
      if (with_hold && !held && sent_items >= target - n / 2) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if ($urandom_range(99) < 80) begin
        play_session();
      end else begin
        send_item(make_sample(action_t'($urandom_range(3)), 1'($urandom_range(1)),
                              ADC_FIELD_W'($urandom_range((1 << ADC_FIELD_W) - 1)),
                              1'($urandom_range(1))));
      end
    end
  endtask

  initial begin
    hjd_cfg_t seg_cfg [6];
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_INSERT_LEVEL_HIGH;
    cfg_wdata_i   = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    rst_ni        = 1'b0;
    hold_req      = 1'b0;
    quiet_cycles  = 0;
    sent_items    = 0;
    src_idle_pct  = 10;
    sink_idle_pct = 66;
    seg_cfg[0] = make_cfg(1'b1, 1'b1, 204, 410, 1024);
    seg_cfg[1] = make_cfg(1'b0, 1'b1, 0, 0, 0);
    seg_cfg[2] = make_cfg(1'b1, 1'b0, 4095, 4095, 4096);
    seg_cfg[3] = make_cfg(1'b0, 1'b1, 3000, 1000, 4096);
    seg_cfg[4] = make_cfg(1'($urandom_range(1)), 1'b1, $urandom_range(4095),
                          $urandom_range(4095), $urandom_range(4096));
    seg_cfg[5] = make_cfg(1'b1, 1'b1, 100, 3900, 2048);
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    for (int seg = 0; seg < 6; seg++) begin
      wait_drained();
      case (seg / 2)
        0: begin
          src_idle_pct  = 10;
          sink_idle_pct = 66;
        end
        1: begin
          src_idle_pct  = 66;
          sink_idle_pct = 10;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      apply_config(seg_cfg[seg]);
      run_random(SEG_ITEMS, seg == 0 || seg == 4);
    end
    wait_drained();
    repeat (4) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: headset_jack_and_hook_detector.f
src/hjd_pkg.sv
src/hjd_if.sv
src/hjd_cfg.sv
src/hjd_core.sv
src/headset_jack_and_hook_detector.sv
verif/headset_jack_and_hook_detector_tb.sv
